### src/mfb_pkg.sv
// Shared types, command codes and the 5x7 font for the monochrome framebuffer blitter.
`default_nettype none
package mfb_pkg;

  // Command codes carried on the kind field.
  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_GLYPH = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Font geometry.
  localparam int FONT_ROWS   = 7;
  localparam int FONT_COLS   = 5;
  localparam int GLYPH_COUNT = 11;

  // Width of the signed working coordinates (position plus extent never overflows).
  localparam int CW = 14;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_CLEAR   = 11'b000_0000_0010,
    ST_SETUP   = 11'b000_0000_0100,
    ST_ROWINIT = 11'b000_0000_1000,
    ST_ROW     = 11'b000_0001_0000,
    ST_RD      = 11'b000_0010_0000,
    ST_WR      = 11'b000_0100_0000,
    ST_GLYPH   = 11'b000_1000_0000,
    ST_GNEXT   = 11'b001_0000_0000,
    ST_READ    = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  // One row of a glyph: leftmost font pixel in bit 7; unknown codes are blank.
  function automatic logic [7:0] font_row(input logic [3:0] code, input logic [2:0] row);
    logic [7:0] r0, r1, r2, r3, r4, r5, r6;
    logic [7:0] res;
    r0 = 8'h00; r1 = 8'h00; r2 = 8'h00; r3 = 8'h00; r4 = 8'h00; r5 = 8'h00; r6 = 8'h00;
    case (code)
      4'd0: begin r0=8'h70; r1=8'h88; r2=8'h98; r3=8'hA8; r4=8'hC8; r5=8'h88; r6=8'h70; end
      4'd1: begin r0=8'h20; r1=8'h60; r2=8'h20; r3=8'h20; r4=8'h20; r5=8'h20; r6=8'h70; end
      4'd2: begin r0=8'h70; r1=8'h88; r2=8'h08; r3=8'h10; r4=8'h20; r5=8'h40; r6=8'hF8; end
      4'd3: begin r0=8'hF8; r1=8'h10; r2=8'h20; r3=8'h10; r4=8'h08; r5=8'h88; r6=8'h70; end
      4'd4: begin r0=8'h10; r1=8'h30; r2=8'h50; r3=8'h90; r4=8'hF8; r5=8'h10; r6=8'h10; end
      4'd5: begin r0=8'hF8; r1=8'h80; r2=8'hF0; r3=8'h08; r4=8'h08; r5=8'h88; r6=8'h70; end
      4'd6: begin r0=8'h30; r1=8'h40; r2=8'h80; r3=8'hF0; r4=8'h88; r5=8'h88; r6=8'h70; end
      4'd7: begin r0=8'hF8; r1=8'h08; r2=8'h10; r3=8'h20; r4=8'h40; r5=8'h40; r6=8'h40; end
      4'd8: begin r0=8'h70; r1=8'h88; r2=8'h88; r3=8'h70; r4=8'h88; r5=8'h88; r6=8'h70; end
      4'd9: begin r0=8'h70; r1=8'h88; r2=8'h88; r3=8'h78; r4=8'h08; r5=8'h10; r6=8'h60; end
      4'd10: begin r5 = 8'h20; r6 = 8'h40; end
      default: begin r0 = 8'h00; end
    endcase
    case (row)
      3'd0: res = r0;
      3'd1: res = r1;
      3'd2: res = r2;
      3'd3: res = r3;
      3'd4: res = r4;
      3'd5: res = r5;
      3'd6: res = r6;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

### src/mono_framebuffer_rect_glyph_draw_core.sv
// Top level of the monochrome framebuffer blitter: command sequencer and frame memory.
`default_nettype none
// The block holds a PANEL_WIDTH x PANEL_HEIGHT 1-bit framebuffer in a single-port
// memory, one byte per eight pixels with the leftmost pixel in bit 7 (0 black,
// 1 white), and runs one command at a time: fill a clipped rectangle, draw a
// scaled 5x7 black glyph, clear to white, or read a byte. Every command returns
// one result transfer. A fill does a read-modify-write on the one memory port for
// every byte it touches, row by row. A glyph with a known code and nonzero scale
// walks its 35 font pixels and fills a scale-by-scale block for every set pixel.
// Clearing writes one byte a cycle, ((PANEL_WIDTH+7)/8)*PANEL_HEIGHT bytes, 48000
// at the default size; the same clearing pass runs after reset, and no command is
// accepted until it has finished. in_ready is high only while the sequencer is
// idle; a finished result may wait on the output while the next command is taken.
module mono_framebuffer_rect_glyph_draw_core
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = 480,
  parameter int PANEL_HEIGHT = 800
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic signed [11:0] x_pos,
  input  wire logic signed [11:0] y_pos,
  input  wire logic [9:0]         rect_width,
  input  wire logic [9:0]         rect_height,
  input  wire logic               black,
  input  wire logic [3:0]         glyph,
  input  wire logic [3:0]         scale,
  input  wire logic [15:0]        byte_addr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              byte_value
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int AW          = $clog2(STORE_BYTES + 1);
  localparam int XW          = $clog2(PANEL_WIDTH + 1);
  localparam int YW          = $clog2(PANEL_HEIGHT + 1);
  localparam int BW          = XW - 3;
  localparam logic signed [CW-1:0] PW_S = CW'(PANEL_WIDTH);
  localparam logic signed [CW-1:0] PH_S = CW'(PANEL_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(STORE_BYTES - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(ROW_BYTES);

  state_t state;

  // Command registers.
  logic signed [CW-1:0] cmd_x;
  logic [3:0]           cmd_glyph;
  logic [3:0]           cmd_scale;
  logic                 is_read;
  logic                 clear_cmd;

  // Rectangle handed to the fill engine.
  logic signed [CW-1:0] rx, ry;
  logic [9:0]           rw, rh;
  logic                 rblk;
  logic                 in_glyph;

  // Glyph walk.
  logic [2:0]           grow, gcol;
  logic signed [CW-1:0] gx, gy;
  logic [7:0]           font_bits;

  // Clipped bounds and walk position of the fill engine.
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic          empty;
  logic [YW-1:0] row;
  logic [BW-1:0] bc;
  logic [AW-1:0] row_base;
  logic [AW-1:0] addr;

  // Frame memory.
  logic [7:0] mem [0:STORE_BYTES-1];
  logic [7:0] rd_data;
  logic       we;
  logic [7:0] wdata;

  // Clipping of the pending rectangle.
  logic signed [CW-1:0] xe, ye, x0c, x1c, y0c, y1c;
  logic [XW-1:0]        x1m;
  logic [BW-1:0]        xb0, xb1;
  logic [7:0]           mask;
  logic signed [CW-1:0] s_ext;
  logic                 last_byte, last_row;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    xe  = rx + $signed({{(CW-10){1'b0}}, rw});
    ye  = ry + $signed({{(CW-10){1'b0}}, rh});
    x0c = (rx < 0) ? '0 : rx;
    y0c = (ry < 0) ? '0 : ry;
    x1c = (xe > PW_S) ? PW_S : xe;
    y1c = (ye > PH_S) ? PH_S : ye;
  end

  // Byte columns covered by the clipped span, and the pixel mask of the current byte.
  always_comb begin
    x1m = x1 - XW'(1);
    xb0 = x0[XW-1:3];
    xb1 = x1m[XW-1:3];
    for (int k = 0; k < 8; k++) begin
      mask[7-k] = ({bc, 3'(k)} >= x0) && ({bc, 3'(k)} < x1);
    end
    last_byte = (bc == xb1);
    last_row  = ((row + YW'(1)) == y1);
  end

  assign s_ext = $signed({{(CW-4){1'b0}}, cmd_scale});

  // Current row of the glyph being drawn.
  assign font_bits = font_row(cmd_glyph, grow);

  // Memory write data: clearing pass or read-modify-write of one byte.
  assign we    = (state == ST_CLEAR) || (state == ST_WR);
  assign wdata = (state == ST_CLEAR) ? 8'hFF : (rblk ? (rd_data & ~mask) : (rd_data | mask));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      addr      <= '0;
      clear_cmd <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A result waiting in ST_DONE reloads the output register itself.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_x     <= CW'(x_pos);
            cmd_glyph <= glyph;
            cmd_scale <= scale;
            is_read   <= (kind == KIND_READ) && (32'(byte_addr) < 32'(STORE_BYTES));
            case (kind)
              KIND_FILL: begin
                rx       <= CW'(x_pos);
                ry       <= CW'(y_pos);
                rw       <= rect_width;
                rh       <= rect_height;
                rblk     <= black;
                in_glyph <= 1'b0;
                state    <= ST_SETUP;
              end
              KIND_GLYPH: begin
                grow <= '0;
                gcol <= '0;
                gx   <= CW'(x_pos);
                gy   <= CW'(y_pos);
                if ((32'(glyph) >= 32'(GLYPH_COUNT)) || (scale == 4'd0)) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_GLYPH;
                end
              end
              KIND_CLEAR: begin
                addr      <= '0;
                clear_cmd <= 1'b1;
                state     <= ST_CLEAR;
              end
              KIND_READ: begin
                addr <= AW'(byte_addr);
                if (32'(byte_addr) < 32'(STORE_BYTES)) begin
                  state <= ST_READ;
                end else begin
                  state <= ST_DONE;
                end
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == LAST_ADDR) begin
            state <= clear_cmd ? ST_DONE : ST_IDLE;
          end
        end
        ST_SETUP: begin
          empty <= (x1c <= x0c) || (y1c <= y0c);
          x0    <= XW'(x0c);
          x1    <= XW'(x1c);
          y0    <= YW'(y0c);
          y1    <= YW'(y1c);
          state <= ST_ROWINIT;
        end
        ST_ROWINIT: begin
          row      <= y0;
          row_base <= AW'(y0) * ROW_STRIDE;
          bc       <= xb0;
          if (empty) begin
            state <= in_glyph ? ST_GNEXT : ST_DONE;
          end else begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          addr  <= row_base + AW'(bc);
          state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (last_byte) begin
            bc       <= xb0;
            row      <= row + YW'(1);
            row_base <= row_base + ROW_STRIDE;
            if (last_row) begin
              state <= in_glyph ? ST_GNEXT : ST_DONE;
            end else begin
              state <= ST_ROW;
            end
          end else begin
            bc    <= bc + BW'(1);
            addr  <= addr + AW'(1);
            state <= ST_RD;
          end
        end
        ST_GLYPH: begin
          // A set font pixel becomes a scale-by-scale black rectangle.
          if (font_bits[3'd7 - gcol]) begin
            rx       <= gx;
            ry       <= gy;
            rw       <= 10'(cmd_scale);
            rh       <= 10'(cmd_scale);
            rblk     <= 1'b1;
            in_glyph <= 1'b1;
            state    <= ST_SETUP;
          end else begin
            state <= ST_GNEXT;
          end
        end
        ST_GNEXT: begin
          if (gcol == 3'(FONT_COLS - 1)) begin
            if (grow == 3'(FONT_ROWS - 1)) begin
              state <= ST_DONE;
            end else begin
              gcol  <= '0;
              grow  <= grow + 3'd1;
              gx    <= cmd_x;
              gy    <= gy + s_ext;
              state <= ST_GLYPH;
            end
          end else begin
            gcol  <= gcol + 3'd1;
            gx    <= gx + s_ext;
            state <= ST_GLYPH;
          end
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hand the result over once the output register is free.
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            byte_value <= is_read ? rd_data : 8'h00;
            clear_cmd  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sim/mfb_draw_checker.sv
// Checker for the framebuffer blitter: keeps a shadow frame, predicts each result and compares.
`timescale 1ns / 1ps

module mfb_draw_checker
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = 480,
  parameter int PANEL_HEIGHT = 800
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [11:0] x_pos,
  input  logic signed [11:0] y_pos,
  input  logic [9:0]         rect_width,
  input  logic [9:0]         rect_height,
  input  logic               black,
  input  logic [3:0]         glyph,
  input  logic [3:0]         scale,
  input  logic [15:0]        byte_addr,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         byte_value,
  output int                 outstanding,
  output int                 mismatch_count
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int GLYPHS      = 11;

  logic [7:0] shadow_frame [0:STORE_BYTES-1];
  logic [7:0] expected_bytes [$];

  // Seven rows of a 5x7 character, first row in the top byte, leftmost pixel in bit 7.
  function automatic logic [55:0] char_rows(int code);
    logic [55:0] rows;
    case (code)
      0:       rows = 56'h70_88_98_A8_C8_88_70;
      1:       rows = 56'h20_60_20_20_20_20_70;
      2:       rows = 56'h70_88_08_10_20_40_F8;
      3:       rows = 56'hF8_10_20_10_08_88_70;
      4:       rows = 56'h10_30_50_90_F8_10_10;
      5:       rows = 56'hF8_80_F0_08_08_88_70;
      6:       rows = 56'h30_40_80_F0_88_88_70;
      7:       rows = 56'hF8_08_10_20_40_40_40;
      8:       rows = 56'h70_88_88_70_88_88_70;
      9:       rows = 56'h70_88_88_78_08_10_60;
      10:      rows = 56'h00_00_00_00_00_20_40;
      default: rows = '0;
    endcase
    return rows;
  endfunction

  // Whole shadow frame back to white.
  function automatic void whiten_frame();
    for (int i = 0; i < STORE_BYTES; i++) begin
      shadow_frame[i] = 8'hFF;
    end
  endfunction

  // Paint a rectangle pixel by pixel, clipped to the panel.
  function automatic void paint_rect(int x, int y, int w, int h, bit blk);
    int x0, y0, x1, y1, idx;
    logic [7:0] mask;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > PANEL_WIDTH) ? PANEL_WIDTH : x + w;
    y1 = (y + h > PANEL_HEIGHT) ? PANEL_HEIGHT : y + h;
    for (int r = y0; r < y1; r++) begin
      for (int c = x0; c < x1; c++) begin
        idx  = r * ROW_BYTES + c / 8;
        mask = 8'h80 >> (c % 8);
        if (blk) begin
          shadow_frame[idx] = shadow_frame[idx] & ~mask;
        end else begin
          shadow_frame[idx] = shadow_frame[idx] | mask;
        end
      end
    end
  endfunction

  // Each set font pixel becomes a black block of scale by scale pixels.
  function automatic void stamp_char(int x, int y, int code, int s);
    logic [55:0] rows;
    if (code >= GLYPHS || s == 0) begin
      return;
    end
    rows = char_rows(code);
    for (int r = 0; r < 7; r++) begin
      for (int c = 0; c < 5; c++) begin
        if (rows[55 - 8 * r - c]) begin
          paint_rect(x + c * s, y + r * s, s, s, 1'b1);
        end
      end
    end
  endfunction

  // Apply one command to the shadow frame and return the byte it should report.
  function automatic logic [7:0] predict_byte(logic [1:0] k, int x, int y, int w, int h,
                                              bit blk, int code, int s, int addr);
    logic [7:0] res;
    res = 8'h00;
    case (k)
      KIND_FILL:  paint_rect(x, y, w, h, blk);
      KIND_GLYPH: stamp_char(x, y, code, s);
      KIND_CLEAR: whiten_frame();
      default: begin
        if (addr < STORE_BYTES) begin
          res = shadow_frame[addr];
        end
      end
    endcase
    return res;
  endfunction

  // Predict on every input transfer, compare on every output transfer.
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      whiten_frame();
      expected_bytes.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_bytes.push_back(predict_byte(kind, int'(x_pos), int'(y_pos),
                                              int'(rect_width), int'(rect_height), black,
                                              int'(glyph), int'(scale), int'(byte_addr)));
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("byte_value transfer with no command outstanding: actual %02h", byte_value);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (byte_value !== want) begin
            $error("byte_value mismatch: expected %02h, actual %02h", want, byte_value);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    outstanding <= expected_bytes.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for the framebuffer blitter: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top
  import mfb_pkg::*;
();

  localparam int PANEL_W        = 480;
  localparam int PANEL_H        = 800;
  localparam int WATCHDOG_LIMIT = 500000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 110;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [1:0]         kind        = KIND_READ;
  logic signed [11:0] x_pos       = '0;
  logic signed [11:0] y_pos       = '0;
  logic [9:0]         rect_width  = '0;
  logic [9:0]         rect_height = '0;
  logic               black       = 1'b0;
  logic [3:0]         glyph       = '0;
  logic [3:0]         scale       = '0;
  logic [15:0]        byte_addr   = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [7:0]         byte_value;

  int outstanding;
  int mismatch_count;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  bit hold_req     = 1'b0;

  mono_framebuffer_rect_glyph_draw_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .black      (black),
    .glyph      (glyph),
    .scale      (scale),
    .byte_addr  (byte_addr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_value (byte_value)
  );

  mfb_draw_checker #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .black         (black),
    .glyph         (glyph),
    .scale         (scale),
    .byte_addr     (byte_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_value    (byte_value),
    .outstanding   (outstanding),
    .mismatch_count(mismatch_count)
  );

  // Free-running 100 MHz clock.
  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Result side: random stalls, with one long hold-off on request counted here.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command, after an optional random gap, and wait for its transfer.
  task automatic send_cmd(input logic [1:0] k, input int x, input int y, input int w,
                          input int h, input bit blk, input int code, input int s,
                          input int addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    kind        <= k;
    x_pos       <= x[11:0];
    y_pos       <= y[11:0];
    rect_width  <= w[9:0];
    rect_height <= h[9:0];
    black       <= blk;
    glyph       <= code[3:0];
    scale       <= s[3:0];
    byte_addr   <= addr[15:0];
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random command: mostly small shapes and reads near the drawn area, rarely large work.
  task automatic send_random();
    int roll, x, y, w, h, code, s, addr;
    logic [1:0] k;
    bit blk;
    roll = $urandom_range(199);
    x    = int'($urandom_range(4095)) - 2048;
    y    = int'($urandom_range(4095)) - 2048;
    w    = $urandom_range(1023);
    h    = $urandom_range(1023);
    blk  = 1'($urandom_range(1));
    code = $urandom_range(15);
    s    = $urandom_range(15);
    addr = $urandom_range(65535);
    if (roll == 0) begin
      k = KIND_CLEAR;
    end else if (roll <= 70) begin
      k = KIND_FILL;
      if ($urandom_range(19) != 0) begin
        x = int'($urandom_range(559)) - 40;
        y = int'($urandom_range(279)) - 40;
        w = $urandom_range(48);
        h = $urandom_range(48);
      end
    end else if (roll <= 130) begin
      k = KIND_GLYPH;
      if ($urandom_range(9) != 0) begin
        x = int'($urandom_range(559)) - 40;
        y = int'($urandom_range(279)) - 40;
      end
      if ($urandom_range(4) != 0) begin
        s = $urandom_range(4);
      end
    end else begin
      k = KIND_READ;
      if ($urandom_range(9) != 0) begin
        addr = $urandom_range(239) * 60 + $urandom_range(59);
      end
    end
    send_cmd(k, x, y, w, h, blk, code, s, addr);
  endtask

  // Main sequence: reset, directed commands, then random phases with varied idling.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: store edges, out-of-range reads, full and off-panel fills, glyph cases.
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 47999);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 48000);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 65535);
    send_cmd(KIND_FILL, 0, 0, 1023, 1023, 1, 0, 0, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 47999);
    send_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 24000);
    send_cmd(KIND_FILL, -2048, -2048, 1023, 1023, 1, 0, 0, 0);
    send_cmd(KIND_FILL, 2047, 2047, 1023, 1023, 1, 0, 0, 0);
    send_cmd(KIND_FILL, -3, -2, 12, 5, 1, 0, 0, 0);
    send_cmd(KIND_FILL, 20, 0, 0, 9, 1, 0, 0, 0);
    send_cmd(KIND_FILL, 20, 0, 9, 0, 1, 0, 0, 0);
    send_cmd(KIND_FILL, 2, 1, 3, 2, 0, 0, 0, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 1);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 60);
    send_cmd(KIND_GLYPH, 476, 796, 0, 0, 0, 8, 1, 0);
    send_cmd(KIND_GLYPH, -1, 10, 0, 0, 0, 10, 2, 0);
    send_cmd(KIND_GLYPH, 100, 100, 0, 0, 0, 15, 3, 0);
    send_cmd(KIND_GLYPH, 200, 20, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_GLYPH, 200, 20, 0, 0, 0, 0, 15, 0);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 47999);
    send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 24 * 60 + 25);
    drain();

    // Long receiver hold-off while reads keep coming, so the block backs up.
    hold_req = 1'b1;
    repeat (12) send_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, $urandom_range(14399));
    drain();

    // Random phases: none, sender gaps, receiver stalls, both, none.
    repeat (PHASE_ITEMS) send_random();
    drain();
    idle_pct = 66;
    repeat (PHASE_ITEMS) send_random();
    drain();
    idle_pct  = 0;
    stall_pct = 66;
    repeat (PHASE_ITEMS) send_random();
    drain();
    idle_pct  = 30;
    stall_pct = 30;
    repeat (PHASE_ITEMS) send_random();
    drain();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (PHASE_ITEMS) send_random();
    drain();

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
